[src/ipdp_pkg.sv]
// Shared types and constants for the interval partition solver.
package ipdp_pkg;

  localparam int IDX_W   = 6;
  localparam int COST_W  = 48;
  localparam int TOTAL_W = 56;

  localparam logic [IDX_W-1:0] SPAN_RESET = 6'd32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  range_start;
    logic [IDX_W-1:0]  range_end;
    logic [COST_W-1:0] segment_cost;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   position;
    logic [IDX_W-1:0]   segment_start;
    logic [TOTAL_W-1:0] total_cost;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;     // write one cost entry from the request
    logic run_init;    // latch span, clear solve counters
    logic mode_trace;  // address memories from trace registers
    logic whole;       // port A reads the whole range instead of the left part
    logic cell_init;   // best <= cost of cell, k <= lo
    logic split_step;  // best <= min(best, split sum), k++
    logic cell_wr;     // write best of cell, advance cell
    logic trace_init;  // root range, clear pending marks
    logic trace_chk;   // latch best of range, k <= lo, q <= lo
    logic trace_push;  // mark right part pending, shrink to left part
    logic trace_next;  // k++
    logic fill;        // segment map write at q, q++
    logic scan;        // look for next pending range end
    logic out_init;    // q <= 0
    logic emit;        // result strobe, q++
  } ipdp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cell_zero;   // span of cell is zero
    logic split_last;  // k is the last split point of the range
    logic row_end;     // cell ends at len
    logic span_end;    // span equals len
    logic seg_eq;      // best of range equals its own segment cost
    logic split_eq;    // split sum equals best of range
    logic fill_end;    // q reached the range end
    logic at_len;      // range end is len
    logic mark_hit;    // position q is a pending range end
    logic out_last;    // q equals len
  } ipdp_status_t;

endpackage

[src/ipdp_datapath.sv]
// Datapath: cost/best/segment memories, index counters and comparators.
module ipdp_datapath import ipdp_pkg::*; #(
  parameter int MAX_SPAN = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr,
  input  logic [IDX_W-1:0] cfg_data,
  input  in_item_t         req,
  input  ipdp_cmd_t        cmd,
  output ipdp_status_t     status,
  output logic             res_strobe,
  output out_item_t        res
);

  localparam int SIDE  = MAX_SPAN + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(SIDE);
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SPAN);

  logic [IDX_W-1:0]  span;
  logic [IDX_W-1:0]  len, p, a, k, ta, tb, q;
  logic [COST_W-1:0] best, best_ab;
  logic [TOTAL_W-1:0] total;
  logic [SIDE-1:0]   mark;

  logic [COST_W-1:0] cost_mem [CELLS];
  logic [COST_W-1:0] best_mem [CELLS];
  logic [IDX_W-1:0]  seg_mem  [SIDE];

  logic [COST_W-1:0] cost_rd, best_rd_a, best_rd_b;
  logic [IDX_W-1:0]  seg_rd;

  logic [IDX_W-1:0] b, lo, hi, k_inc;
  logic [AW-1:0]    addr_cost, addr_a, addr_b, addr_load, addr_cell;
  logic [COST_W:0]  sum;
  logic             load_ok;

  function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    return AW'(r) * AW'(SIDE) + AW'(c);
  endfunction

  assign b      = a + p;
  assign lo     = cmd.mode_trace ? ta : a;
  assign hi     = cmd.mode_trace ? tb : b;
  assign k_inc  = k + 1'b1;

  assign addr_cost = cell_addr(lo, hi);
  assign addr_a    = cmd.whole ? cell_addr(lo, hi) : cell_addr(lo, k);
  assign addr_b    = cell_addr(k_inc, hi);
  assign addr_load = cell_addr(req.range_start, req.range_end);
  assign addr_cell = cell_addr(a, b);
  assign sum       = {1'b0, best_rd_a} + {1'b0, best_rd_b};

  assign load_ok = (req.range_start <= MAX_IDX) && (req.range_end <= MAX_IDX) &&
                   (req.range_start <= req.range_end);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      cost_mem[addr_load] <= req.segment_cost;
    end
    cost_rd <= cost_mem[addr_cost];
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_wr) begin
      best_mem[addr_cell] <= best;
    end
    best_rd_a <= best_mem[addr_a];
    best_rd_b <= best_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      seg_mem[q[SW-1:0]] <= ta;
    end
    seg_rd <= seg_mem[q[SW-1:0]];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_RESET;
    end else if (cfg_wr) begin
      span <= cfg_data;
    end
  end

  // solve counters
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      len <= (span > MAX_IDX) ? MAX_IDX : span;
      p   <= '0;
      a   <= '0;
    end
    if (cmd.cell_init) begin
      best <= cost_rd;
      k    <= lo;
    end
    if (cmd.split_step) begin
      if (sum < {1'b0, best}) begin
        best <= sum[COST_W-1:0];
      end
      k <= k_inc;
    end
    if (cmd.cell_wr) begin
      if (b == len) begin
        a <= '0;
        p <= p + 1'b1;
        if (p == len) begin
          total <= TOTAL_W'(best);
        end
      end else begin
        a <= a + 1'b1;
      end
    end
    // trace
    if (cmd.trace_init) begin
      ta   <= '0;
      tb   <= len;
      mark <= '0;
    end
    if (cmd.trace_chk) begin
      best_ab <= best_rd_a;
      k       <= ta;
    end
    if (cmd.trace_push) begin
      mark[tb[SW-1:0]] <= 1'b1;
      tb <= k;
    end
    if (cmd.trace_next) begin
      k <= k_inc;
    end
    if (cmd.fill) begin
      if (q == tb) begin
        ta <= q + 1'b1;
      end
    end
    if (cmd.scan) begin
      if (mark[q[SW-1:0]]) begin
        tb <= q;
        mark[q[SW-1:0]] <= 1'b0;
      end
    end
    // position counter: fill/scan during trace, then the result walk
    if (cmd.trace_chk) begin
      q <= ta;
    end else if (cmd.out_init) begin
      q <= '0;
    end else if (cmd.fill || cmd.emit || (cmd.scan && !mark[q[SW-1:0]])) begin
      q <= q + 1'b1;
    end
  end

  always_comb begin
    status.cell_zero  = (p == '0);
    status.split_last = (k_inc == hi);
    status.row_end    = (b == len);
    status.span_end   = (p == len);
    status.seg_eq     = (best_rd_a == cost_rd);
    status.split_eq   = (sum == {1'b0, best_ab});
    status.fill_end   = (q == tb);
    status.at_len     = (tb == len);
    status.mark_hit   = mark[q[SW-1:0]];
    status.out_last   = (q == len);
  end

  assign res_strobe        = cmd.emit;
  assign res.position      = q;
  assign res.segment_start = seg_rd;
  assign res.total_cost    = total;
  assign res.last          = (q == len);

endmodule

[src/ipdp_ctrl.sv]
// Controller: sequences load, solve, trace-back and result phases.
module ipdp_ctrl import ipdp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         operation,
  input  ipdp_status_t status,
  output ipdp_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CELL_RD, ST_CELL_INIT, ST_SPLIT_RD, ST_SPLIT_CMP, ST_CELL_WR,
    ST_TRACE_RD, ST_TRACE_CHK, ST_TSPLIT_RD, ST_TSPLIT_CMP, ST_FILL, ST_SCAN,
    ST_OUT_RD, ST_OUT_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_RUN) begin
            cmd.run_init = 1'b1;
            state_next   = ST_CELL_RD;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_CELL_RD: begin
        state_next = ST_CELL_INIT;
      end
      ST_CELL_INIT: begin
        cmd.cell_init = 1'b1;
        state_next    = status.cell_zero ? ST_CELL_WR : ST_SPLIT_RD;
      end
      ST_SPLIT_RD: begin
        state_next = ST_SPLIT_CMP;
      end
      ST_SPLIT_CMP: begin
        cmd.split_step = 1'b1;
        state_next     = status.split_last ? ST_CELL_WR : ST_SPLIT_RD;
      end
      ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        if (status.row_end && status.span_end) begin
          cmd.trace_init = 1'b1;
          state_next     = ST_TRACE_RD;
        end else begin
          state_next = ST_CELL_RD;
        end
      end
      ST_TRACE_RD: begin
        cmd.mode_trace = 1'b1;
        cmd.whole      = 1'b1;
        state_next     = ST_TRACE_CHK;
      end
      ST_TRACE_CHK: begin
        cmd.mode_trace = 1'b1;
        cmd.trace_chk  = 1'b1;
        state_next     = status.seg_eq ? ST_FILL : ST_TSPLIT_RD;
      end
      ST_TSPLIT_RD: begin
        cmd.mode_trace = 1'b1;
        state_next     = ST_TSPLIT_CMP;
      end
      ST_TSPLIT_CMP: begin
        cmd.mode_trace = 1'b1;
        if (status.split_eq) begin
          cmd.trace_push = 1'b1;
          state_next     = ST_TRACE_RD;
        end else if (status.split_last) begin
          state_next = ST_FILL;
        end else begin
          cmd.trace_next = 1'b1;
          state_next     = ST_TSPLIT_RD;
        end
      end
      ST_FILL: begin
        cmd.mode_trace = 1'b1;
        cmd.fill       = 1'b1;
        if (status.fill_end) begin
          if (status.at_len) begin
            cmd.out_init = 1'b1;
            state_next   = ST_OUT_RD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.mode_trace = 1'b1;
        cmd.scan       = 1'b1;
        if (status.mark_hit) begin
          state_next = ST_TRACE_RD;
        end
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = status.out_last ? ST_IDLE : ST_OUT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

[src/interval_partition_dp.sv]
// Top level of the interval partition dynamic-programming solver.
//
// Usage:
//   Command channel: a request transfers on a clock edge with start high
//   and busy low. A load request (operation = load) writes the cost of one
//   range [range_start, range_end] and is done in that cycle; busy stays
//   low, so loads can stream one per cycle. Loads outside 0..MAX_SPAN or
//   with start above end are dropped.
//   A run request raises busy until its last result has been sent. The
//   run solves all ranges of 0..len (len = span_length clipped to
//   MAX_SPAN), walking cells short to long: each cell reads its cost, then
//   reads and compares its split points one at a time, bounded by the
//   single best memory pair of read ports, then writes its best. Trace-back
//   then checks each range and tries its split points, plus a map fill and
//   at most one pending-range scan step per position. Results are each read
//   from the segment map, then emitted; len+1 results, the last with last set.
//   Results: res_strobe marks res for exactly one cycle; the receiver
//   cannot stall, every strobe is a transfer.
//   Config: cfg_data transfers on cfg_valid && cfg_ready; cfg_ready is
//   high while idle. Reset sets span_length to 32 and returns to idle; the
//   cost table holds nothing meaningful until loaded.
module interval_partition_dp import ipdp_pkg::*; #(
  parameter int MAX_SPAN = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         req,
  output logic             res_strobe,
  output out_item_t        res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_data
);

  ipdp_cmd_t    cmd;
  ipdp_status_t status;

  assign cfg_ready = !busy;

  ipdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start && !busy),
    .operation (req.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  ipdp_datapath #(
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .req        (req),
    .cmd        (cmd),
    .status     (status),
    .res_strobe (res_strobe),
    .res        (res)
  );

endmodule

[src/ipdp_checker.sv]
// Port-level checks for the interval partition solver, bound to the top.
module ipdp_checker import ipdp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input in_item_t         req,
  input logic             res_strobe,
  input out_item_t        res,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [IDX_W-1:0] cfg_data
);

  a_res_in_run: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> busy) else $error("result outside a run");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res_strobe && res.last |=> !res_strobe && !busy) else $error("run did not end");

  a_next_pos: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !res.last |-> ##2 res_strobe && (res.position == $past(res.position, 2) + 1'b1))
    else $error("result sequence broken");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.operation == OP_RUN |=> busy) else $error("run not started");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.operation == OP_LOAD |=> !busy && !res_strobe)
    else $error("load disturbed idle");

endmodule

bind interval_partition_dp ipdp_checker u_ipdp_checker (.*);
